@@ hw/rtl/hdp_pkg.sv @@
// Package for the image header dimension parser.
// Holds the item types, kind codes and header byte constants.
// No dependencies.
`default_nettype none

package hdp_pkg;

    localparam int COUNT_BITS_DEF = 32;

    // bytes kept behind the newest one for the marker window
    localparam int HIST_DEPTH = 8;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_PNG     = 2'd1;
    localparam logic [1:0] KIND_JPEG    = 2'd2;

    localparam logic [7:0] PNG_SIG0 = 8'h89;
    localparam logic [7:0] PNG_SIG1 = 8'h50;
    localparam logic [7:0] PNG_SIG2 = 8'h4E;
    localparam logic [7:0] PNG_SIG3 = 8'h47;

    localparam logic [7:0] JPEG_MARK = 8'hFF;
    localparam logic [7:0] JPEG_SOI  = 8'hD8;
    localparam logic [7:0] JPEG_SOF0 = 8'hC0;
    localparam logic [7:0] JPEG_SOF3 = 8'hC3;

    localparam int PNG_WIDTH_FIRST  = 16;
    localparam int PNG_WIDTH_LAST   = 19;
    localparam int PNG_HEIGHT_LAST  = 23;
    localparam int LEAD_LEN         = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } hdp_in_t;

    typedef struct packed {
        logic [1:0]  image_kind;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } hdp_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/hdp_sniff.sv @@
// Header sniffing core: byte counter, lead bytes, marker window and scan walk.
// Uses hdp_pkg. Produces the result item combinationally on the last byte.
`default_nettype none

module hdp_sniff
    import hdp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire hdp_in_t  item,
    output hdp_out_t      res
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] SCAN_RST = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] IDX_LEAD = COUNT_BITS'(LEAD_LEN);
    localparam logic [COUNT_BITS-1:0] IDX_WIN  = COUNT_BITS'(HIST_DEPTH);
    localparam logic [COUNT_BITS-1:0] IDX_W0   = COUNT_BITS'(PNG_WIDTH_FIRST);
    localparam logic [COUNT_BITS-1:0] IDX_W3   = COUNT_BITS'(PNG_WIDTH_LAST);
    localparam logic [COUNT_BITS-1:0] IDX_H3   = COUNT_BITS'(PNG_HEIGHT_LAST);
    localparam int SUM_BITS = COUNT_BITS + 2;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] scan_reg, scan_next;
    logic [7:0]            hist_reg [HIST_DEPTH];
    logic [7:0]            lead_reg [LEAD_LEN];
    logic [31:0]           width_reg, width_next;
    logic [31:0]           height_reg, height_next;
    logic                  found_reg, found_next;

    logic                  is_png, is_jpeg, jpeg_check, is_sof;
    logic [16:0]           skip_amt;
    logic [SUM_BITS-1:0]   scan_sum;
    logic [COUNT_BITS-1:0] scan_adv;

    // all lead-byte tests need index 4 or later, so the stored lead is complete
    assign is_png  = (lead_reg[0] == PNG_SIG0) && (lead_reg[1] == PNG_SIG1) &&
                     (lead_reg[2] == PNG_SIG2) && (lead_reg[3] == PNG_SIG3);
    assign is_jpeg = (lead_reg[0] == JPEG_MARK) && (lead_reg[1] == JPEG_SOI);

    // window position k of the model is hist_reg[k] for k < 8 and the new byte at 8
    assign jpeg_check = (count_reg >= IDX_WIN) && !found_reg && is_jpeg &&
                        ((count_reg - IDX_WIN) == scan_reg);
    assign is_sof     = (hist_reg[1] >= JPEG_SOF0) && (hist_reg[1] <= JPEG_SOF3);

    always_comb
    begin
        if (hist_reg[0] == JPEG_MARK)
        begin
            skip_amt = {1'b0, hist_reg[2], hist_reg[3]} + 17'd2;
        end
        else
        begin
            skip_amt = 17'd1;
        end
        scan_sum = {2'b00, scan_reg} + SUM_BITS'(skip_amt);
        // saturate when the sum runs past the counter range
        scan_adv = (scan_sum[SUM_BITS-1:COUNT_BITS] != 2'b00) ? CNT_MAX
                                                              : scan_sum[COUNT_BITS-1:0];
    end

    always_comb
    begin
        count_next  = (count_reg != CNT_MAX) ? count_reg + CNT_ONE : count_reg;
        scan_next   = scan_reg;
        width_next  = width_reg;
        height_next = height_reg;
        found_next  = found_reg;

        if ((count_reg >= IDX_W0) && (count_reg <= IDX_H3) && is_png)
        begin
            if (count_reg <= IDX_W3)
            begin
                width_next = {width_reg[23:0], item.data_byte};
            end
            else
            begin
                height_next = {height_reg[23:0], item.data_byte};
            end
        end

        if (jpeg_check)
        begin
            if ((hist_reg[0] == JPEG_MARK) && is_sof)
            begin
                height_next = {16'h0000, hist_reg[5], hist_reg[6]};
                width_next  = {16'h0000, hist_reg[7], item.data_byte};
                found_next  = 1'b1;
            end
            else
            begin
                scan_next = scan_adv;
            end
        end

        res.image_kind   = KIND_UNKNOWN;
        res.image_width  = 32'h0;
        res.image_height = 32'h0;
        if ((count_reg >= IDX_H3) && is_png)
        begin
            res.image_kind   = KIND_PNG;
            res.image_width  = width_next;
            res.image_height = height_next;
        end
        else if ((count_reg >= IDX_LEAD) && is_jpeg && found_next)
        begin
            res.image_kind   = KIND_JPEG;
            res.image_width  = width_next;
            res.image_height = height_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scan_reg   <= SCAN_RST;
            width_reg  <= '0;
            height_reg <= '0;
            found_reg  <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
            for (int k = 0; k < LEAD_LEN; k++)
            begin
                lead_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                // start a fresh buffer with the next item
                count_reg  <= '0;
                scan_reg   <= SCAN_RST;
                width_reg  <= '0;
                height_reg <= '0;
                found_reg  <= 1'b0;
                for (int k = 0; k < HIST_DEPTH; k++)
                begin
                    hist_reg[k] <= '0;
                end
                for (int k = 0; k < LEAD_LEN; k++)
                begin
                    lead_reg[k] <= '0;
                end
            end
            else
            begin
                count_reg  <= count_next;
                scan_reg   <= scan_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                found_reg  <= found_next;
                for (int k = 0; k < HIST_DEPTH - 1; k++)
                begin
                    hist_reg[k] <= hist_reg[k+1];
                end
                hist_reg[HIST_DEPTH-1] <= item.data_byte;
                if (count_reg < IDX_LEAD)
                begin
                    lead_reg[count_reg[1:0]] <= item.data_byte;
                end
            end
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> (count_reg == '0) && !found_reg)
        else $error("state not cleared after last item");

    a_frame_needs_jpeg: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> is_jpeg)
        else $error("frame found without JPEG lead");

    a_scan_floor: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg >= SCAN_RST)
        else $error("scan position below start");

endmodule

`default_nettype wire

@@ hw/rtl/image_header_dimension_parser.sv @@
// Image header dimension parser: takes a buffer one byte per item and reports
// the image kind, width and height on the byte flagged last.
//
// Input channel byte_*: one hdp_in_t item per accepted cycle (byte_valid high,
// byte_stall low). Output channel result_*: one hdp_out_t item per buffer.
// A last byte goes from the input register through the sniffing core into the
// result register, which drives result_valid. Throughput: one byte per cycle,
// set by the single registered pass through the sniffing core, unless a last
// byte waits on a pending result; other bytes never wait on the output side.
// Reset clears all buffer state, so the first byte after reset opens a new
// buffer; each result item also clears it for the following buffer.
// While result_stall holds a pending result, the input register keeps
// draining non-last bytes; a further last byte waits in the input register
// and byte_stall rises until the pending result is taken.
// Depends on hdp_pkg and hdp_sniff.
`default_nettype none

module image_header_dimension_parser
    import hdp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire hdp_in_t  byte_item,
    output logic          result_valid,
    input  wire logic     result_stall,
    output hdp_out_t      result_item
);

    hdp_in_t  item_reg;
    logic     item_valid_reg;
    hdp_out_t result_reg;
    logic     result_valid_reg;
    hdp_out_t res;
    logic     advance;

    assign advance    = item_valid_reg &&
                        (!item_reg.last_byte || !result_valid_reg || !result_stall);
    assign byte_stall = item_valid_reg && !advance;

    hdp_sniff #(
        .COUNT_BITS (COUNT_BITS)
    ) u_sniff (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            item_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            item_reg <= byte_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && item_reg.last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_reg.last_byte)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |-> !(advance && item_reg.last_byte))
        else $error("pending result overwritten");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.last_byte |=> result_valid_reg)
        else $error("last item gave no result");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> item_valid_reg && item_reg.last_byte && result_valid_reg)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

@@ dv/image_header_dimension_parser_tb.sv @@
`timescale 1ns / 1ps
// Testbench for image_header_dimension_parser: directed buffers with typed expected
// sizes, then random PNG, JPEG and noise buffers checked against a local size sniffer.
// Depends on hdp_pkg and the parser RTL.

module testbench;
    import hdp_pkg::*;

    localparam longint unsigned COUNT_TOP =
        (COUNT_BITS_DEF >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                               : (64'd1 << COUNT_BITS_DEF) - 64'd1;
    localparam longint unsigned SCAN_START   = 64'd2;
    localparam int              RANDOM_BYTES = 750;
    localparam int              STALL_PCT    = 29;
    localparam int              IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        hdp_out_t   want;
    } probe_row_t;

    localparam hdp_out_t NONE = '0;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     byte_valid = 1'b0;
    logic     byte_stall;
    hdp_in_t  byte_item = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    hdp_out_t result_item;

    // sniffer state
    longint unsigned seen_count;
    longint unsigned scan_at;
    logic [7:0]      win [HIST_DEPTH + 1];
    logic [7:0]      lead [LEAD_LEN];
    logic [31:0]     wid;
    logic [31:0]     hgt;
    logic            sof_seen;

    hdp_out_t sizes_due [$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       quiet = 1'b0;

    probe_row_t probe_rows [41] = '{
        // a lone byte: nothing recognisable
        '{8'hFF, 1'b1, 1'b1, '{KIND_UNKNOWN, 32'd0, 32'd0}},
        // PNG lead, buffer too short
        '{8'h89, 1'b0, 1'b0, NONE}, '{8'h50, 1'b0, 1'b0, NONE},
        '{8'h4E, 1'b0, 1'b0, NONE}, '{8'h47, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b1, '{KIND_UNKNOWN, 32'd0, 32'd0}},
        // JPEG with SOF3 at the first scan position
        '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hD8, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hC3, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE}, '{8'h11, 1'b0, 1'b0, NONE},
        '{8'h08, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h01, 1'b1, 1'b1, '{KIND_JPEG, 32'd1, 32'd65535}},
        // shortest full PNG, widest width, zero height
        '{8'h89, 1'b0, 1'b0, NONE}, '{8'h50, 1'b0, 1'b0, NONE},
        '{8'h4E, 1'b0, 1'b0, NONE}, '{8'h47, 1'b0, 1'b0, NONE},
        '{8'h0D, 1'b0, 1'b0, NONE}, '{8'h0A, 1'b0, 1'b0, NONE},
        '{8'h1A, 1'b0, 1'b0, NONE}, '{8'h0A, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE}, '{8'h0D, 1'b0, 1'b0, NONE},
        '{8'h49, 1'b0, 1'b0, NONE}, '{8'h48, 1'b0, 1'b0, NONE},
        '{8'h44, 1'b0, 1'b0, NONE}, '{8'h52, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b1, '{KIND_PNG, 32'hFFFF_FFFF, 32'd0}}
    };

    image_header_dimension_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_sniffer();
        seen_count = 0;
        scan_at    = SCAN_START;
        foreach (win[i]) win[i] = 8'h00;
        foreach (lead[i]) lead[i] = 8'h00;
        wid      = '0;
        hgt      = '0;
        sof_seen = 1'b0;
    endfunction

    // Advance the sniffer by one byte; return 1 with the sizes on a last byte.
    function automatic bit sniff_next_byte(input hdp_in_t it, output hdp_out_t sizes);
        longint unsigned idx;
        longint unsigned step;
        logic            png;
        logic            jpg;
        idx = seen_count;
        if (seen_count < COUNT_TOP)
            seen_count++;
        for (int i = 0; i < HIST_DEPTH; i++)
            win[i] = win[i + 1];
        win[HIST_DEPTH] = it.data_byte;
        if (idx < LEAD_LEN)
            lead[idx[1:0]] = it.data_byte;
        png = lead[0] == PNG_SIG0 && lead[1] == PNG_SIG1 && lead[2] == PNG_SIG2 &&
              lead[3] == PNG_SIG3;
        jpg = lead[0] == JPEG_MARK && lead[1] == JPEG_SOI;

        if (idx >= PNG_WIDTH_FIRST && idx <= PNG_HEIGHT_LAST && png)
        begin
            if (idx <= PNG_WIDTH_LAST)
                wid = {wid[23:0], it.data_byte};
            else
                hgt = {hgt[23:0], it.data_byte};
        end

        // the step at a scan position falls due once the window holds it in its oldest slot
        if (idx >= HIST_DEPTH && !sof_seen && idx - HIST_DEPTH == scan_at && jpg)
        begin
            if (win[0] == JPEG_MARK && win[1] >= JPEG_SOF0 && win[1] <= JPEG_SOF3)
            begin
                hgt      = {16'd0, win[5], win[6]};
                wid      = {16'd0, win[7], win[8]};
                sof_seen = 1'b1;
            end
            else
            begin
                step = (win[0] == JPEG_MARK) ? 64'd2 + {win[2], win[3]} : 64'd1;
                scan_at = (scan_at >= COUNT_TOP || step > COUNT_TOP - scan_at) ? COUNT_TOP
                                                                              : scan_at + step;
            end
        end

        if (!it.last_byte)
            return 1'b0;
        if (idx >= PNG_HEIGHT_LAST && png)
            sizes = '{KIND_PNG, wid, hgt};
        else if (idx >= LEAD_LEN && jpg && sof_seen)
            sizes = '{KIND_JPEG, wid, hgt};
        else
            sizes = '{KIND_UNKNOWN, 32'd0, 32'd0};
        clear_sniffer();
        return 1'b1;
    endfunction

    // Offer one item, with a random gap first, and hold it until taken.
    task automatic send_byte(input hdp_in_t it);
        while (!quiet && $urandom_range(99) < STALL_PCT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
        result_stall <= !quiet && $urandom_range(99) < STALL_PCT;

    always @(posedge clk)
    begin
        hdp_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (sizes_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: kind %0d width %0d height %0d",
                             result_item.image_kind, result_item.image_width,
                             result_item.image_height);
                mismatches++;
            end
            else
            begin
                want = sizes_due.pop_front();
                if (result_item.image_kind !== want.image_kind ||
                    result_item.image_width !== want.image_width ||
                    result_item.image_height !== want.image_height)
                begin
                    if (mismatches < 10)
                        $display("expected kind %0d w %0d h %0d, got kind %0d w %0d h %0d",
                                 want.image_kind, want.image_width, want.image_height,
                                 result_item.image_kind, result_item.image_width,
                                 result_item.image_height);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("image_header_dimension_parser: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] image_bytes [$];
        hdp_in_t    it;
        hdp_out_t   sizes;
        int         random_bytes;
        int         shape;
        int         n;
        int         seg_len;
        bit         paused;
        clear_sniffer();
        random_bytes = 0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[r])
        begin
            it = '{probe_rows[r].data, probe_rows[r].last};
            send_byte(it);
            if (sniff_next_byte(it, sizes))
                sizes_due.push_back(probe_rows[r].typed ? probe_rows[r].want : sizes);
        end

        while (random_bytes < RANDOM_BYTES)
        begin
            quiet = random_bytes >= 250 && random_bytes < 400;
            // hold off once until the parser has drained
            if (!paused && random_bytes >= 500)
            begin
                paused = 1'b1;
                byte_valid <= 1'b0;
                @(posedge clk);
                while (sizes_due.size() != 0)
                    @(posedge clk);
            end

            image_bytes.delete();
            shape = $urandom_range(19);
            if (shape < 9)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(23, 4) : $urandom_range(40, 24);
                image_bytes = '{PNG_SIG0, PNG_SIG1, PNG_SIG2, PNG_SIG3};
                while (image_bytes.size() < n)
                    image_bytes.push_back(8'($urandom_range(255)));
            end
            else if (shape < 18)
            begin
                image_bytes = '{JPEG_MARK, JPEG_SOI};
                repeat ($urandom_range(4))
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        // filler bytes: the scan steps over them one at a time
                        repeat ($urandom_range(3, 1))
                            image_bytes.push_back(8'($urandom_range(254)));
                    end
                    else
                    begin
                        seg_len = ($urandom_range(15) == 0) ? $urandom_range(16'hFFFF)
                                                             : $urandom_range(12);
                        image_bytes.push_back(JPEG_MARK);
                        if ($urandom_range(3) == 0)
                            image_bytes.push_back(8'($urandom_range(8'hBF)));
                        else
                            image_bytes.push_back(8'($urandom_range(8'hFF, 8'hC4)));
                        image_bytes.push_back(8'(seg_len >> 8));
                        image_bytes.push_back(8'(seg_len));
                        repeat ((seg_len > 2 && seg_len <= 12) ? seg_len - 2 : 0)
                            image_bytes.push_back(8'($urandom_range(255)));
                    end
                end
                if ($urandom_range(7) != 0)
                begin
                    image_bytes.push_back(JPEG_MARK);
                    image_bytes.push_back(8'($urandom_range(JPEG_SOF3, JPEG_SOF0)));
                    repeat (7)
                        image_bytes.push_back(8'($urandom_range(255)));
                end
                repeat ($urandom_range(3))
                    image_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(30, 1))
                    image_bytes.push_back(8'($urandom_range(255)));
            end

            // damage a share of the buffers: flip one bit, or cut the tail off
            if ($urandom_range(9) == 0)
                image_bytes[$urandom_range(image_bytes.size() - 1)] ^= 8'h01 << $urandom_range(7);
            if ($urandom_range(9) == 0)
            begin
                n = $urandom_range(image_bytes.size(), 1);
                while (image_bytes.size() > n)
                    void'(image_bytes.pop_back());
            end

            foreach (image_bytes[i])
            begin
                it = '{image_bytes[i], i == image_bytes.size() - 1};
                send_byte(it);
                if (sniff_next_byte(it, sizes))
                    sizes_due.push_back(sizes);
                random_bytes++;
            end
        end

        quiet = 1'b0;
        byte_valid <= 1'b0;
        @(posedge clk);
        while (sizes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && sizes_due.size() == 0)
            $display("image_header_dimension_parser: match");
        else
            $display("image_header_dimension_parser: mismatch");
        $finish;
    end

endmodule
